>>> design/dcl_pkg.sv
// ----------------------------------------------------------------------------
// dcl_pkg
// Types and constants shared by the dedup cost ledger modules.
// ----------------------------------------------------------------------------
package dcl_pkg;

    localparam int KEY_W      = 64;
    localparam int COST_W     = 64;
    localparam int LAYER_W    = 6;
    localparam int EXPERT_W   = 9;
    localparam int STORED_EXPERT_W = 8;
    localparam int DISP_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int LIMIT_W    = 7;
    localparam int ENTRY_CNT_W = 7;

    localparam logic [LAYER_W-1:0]  LAYER_LIMIT  = 6'd43;
    localparam logic [EXPERT_W-1:0] EXPERT_LIMIT = 9'd256;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 7'd64;

    localparam logic [DISP_W-1:0] DISP_HIT      = 2'd0;
    localparam logic [DISP_W-1:0] DISP_JOIN     = 2'd1;
    localparam logic [DISP_W-1:0] DISP_NEW_MISS = 2'd2;
    localparam logic [DISP_W-1:0] DISP_INVALID  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_DRIFT    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0]    req_ident;
        logic [KEY_W-1:0]    req_gen;
        logic [KEY_W-1:0]    plan_seq;
        logic [LAYER_W-1:0]  layer_index;
        logic [EXPERT_W-1:0] expert_index;
        logic [DISP_W-1:0]   disposition;
        logic [COST_W-1:0]   observed_cost;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status_code;
        logic [COST_W-1:0]      charged_cost;
        logic [COST_W-1:0]      running_total;
        logic [ENTRY_CNT_W-1:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]           req_ident;
        logic [KEY_W-1:0]           generation;
        logic [KEY_W-1:0]           plan_seq;
        logic [LAYER_W-1:0]         layer;
        logic [STORED_EXPERT_W-1:0] expert;
        logic [COST_W-1:0]          cost;
    } entry_t;

    typedef struct packed {
        logic hit;
        logic drift;
    } cell_flags_t;

endpackage

>>> design/dedup_cost_ledger.sv
// ----------------------------------------------------------------------------
// dedup_cost_ledger
// Debit ledger that charges each distinct miss key once.
// ----------------------------------------------------------------------------
// A request passes through the accept state, a compare state in which every
// slot of the cell row compares its entry with the request and registers a
// hit and a drift flag, and a decision state that combines the flags, does
// the 64-bit total add and loads the result register. A new request is
// accepted while an earlier result still waits in that register; the
// decision cycle stalls only when the result register is still occupied.
// Appended entries enter the row at slot 0 and shift one slot on; the row
// holds TABLE_DEPTH entries and is not cleared at reset, only the entry
// count and the total are.
// ----------------------------------------------------------------------------
module dedup_cost_ledger #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [dcl_pkg::LIMIT_W-1:0]  cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  dcl_pkg::req_t                s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output dcl_pkg::rsp_t                m_data
);
    import dcl_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_COMPARE = 2'd1;
    localparam logic [1:0] ST_DECIDE  = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [COST_W-1:0]  total_reg;
    logic [COST_W-1:0]  total_next;
    req_t               req_reg;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;
    logic               m_valid_reg;
    logic               m_valid_next;

    entry_t             query;
    entry_t             chain [TABLE_DEPTH+1];
    cell_flags_t        cell_flags [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] hit_vec;
    logic [TABLE_DEPTH-1:0] drift_vec;
    logic               any_hit;
    logic               any_drift;
    logic               key_ok;
    logic               full;
    logic [COST_W:0]    sum;
    logic               append;
    logic               decide;
    logic               out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign decide   = (state_reg == ST_DECIDE) && out_free;

    always_comb begin
        query.req_ident  = req_reg.req_ident;
        query.generation = req_reg.req_gen;
        query.plan_seq   = req_reg.plan_seq;
        query.layer      = req_reg.layer_index;
        query.expert     = req_reg.expert_index[STORED_EXPERT_W-1:0];
        query.cost       = req_reg.observed_cost;
    end

    assign chain[0] = query;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            dcl_cell #(
                .INDEX (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .shift_en  (append),
                .entry_in  (chain[g]),
                .query     (query),
                .count     (count_reg),
                .entry_out (chain[g+1]),
                .flags     (cell_flags[g])
            );
            assign hit_vec[g]   = cell_flags[g].hit;
            assign drift_vec[g] = cell_flags[g].drift;
        end
    endgenerate

    assign any_hit   = |hit_vec;
    assign any_drift = |drift_vec;

    assign key_ok = (req_reg.req_ident != '0) &&
                    (req_reg.req_gen != '0) &&
                    (req_reg.plan_seq != '0) &&
                    (req_reg.layer_index < LAYER_LIMIT) &&
                    (req_reg.expert_index < EXPERT_LIMIT) &&
                    (req_reg.disposition != DISP_INVALID);

    assign full = (32'(count_reg) >= 32'(TABLE_DEPTH)) ||
                  (32'(count_reg) >= 32'(limit_reg));
    assign sum  = {1'b0, total_reg} + {1'b0, req_reg.observed_cost};

    always_comb begin
        logic [STATUS_W-1:0] status;
        status = STATUS_OK;
        append = 1'b0;
        priority if (!key_ok) begin
            status = STATUS_INVALID;
        end else if (req_reg.disposition != DISP_NEW_MISS) begin
            status = (req_reg.observed_cost != '0) ? STATUS_INVALID : STATUS_OK;
        end else if (req_reg.observed_cost == '0) begin
            status = STATUS_INVALID;
        end else if (any_hit) begin
            status = any_drift ? STATUS_DRIFT : STATUS_OK;
        end else if (full) begin
            status = STATUS_FULL;
        end else if (sum[COST_W]) begin
            status = STATUS_OVERFLOW;
        end else begin
            status = STATUS_OK;
            append = decide;
        end

        count_next = append ? count_reg + CNT_W'(1) : count_reg;
        total_next = append ? sum[COST_W-1:0] : total_reg;

        rsp_next.status_code   = status;
        rsp_next.charged_cost  = append ? req_reg.observed_cost : '0;
        rsp_next.running_total = total_next;
        rsp_next.entry_count   = ENTRY_CNT_W'(count_next);
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            limit_reg   <= LIMIT_RESET;
            count_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        if (decide) begin
            rsp_reg <= rsp_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

endmodule

>>> design/dcl_cell.sv
// ----------------------------------------------------------------------------
// dcl_cell
// One ledger slot: holds an entry, shifts it on to the next slot on append,
// and compares it against the pending request.
// ----------------------------------------------------------------------------
module dcl_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 shift_en,
    input  dcl_pkg::entry_t      entry_in,
    input  dcl_pkg::entry_t      query,
    input  logic [CNT_W-1:0]     count,
    output dcl_pkg::entry_t      entry_out,
    output dcl_pkg::cell_flags_t flags
);
    import dcl_pkg::*;

    entry_t      entry_reg;
    cell_flags_t flags_reg;
    cell_flags_t flags_next;
    logic        occupied;
    logic        key_eq;

    assign occupied = count > CNT_W'(INDEX);
    assign key_eq   = (entry_reg.req_ident == query.req_ident) &&
                      (entry_reg.generation == query.generation) &&
                      (entry_reg.plan_seq == query.plan_seq) &&
                      (entry_reg.layer == query.layer) &&
                      (entry_reg.expert == query.expert);

    always_comb begin
        flags_next.hit   = occupied && key_eq;
        flags_next.drift = occupied && key_eq && (entry_reg.cost != query.cost);
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            entry_reg <= entry_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else begin
            flags_reg <= flags_next;
        end
    end

    assign entry_out = entry_reg;
    assign flags     = flags_reg;

endmodule

>>> tb/tb_dedup_cost_ledger.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dedup_cost_ledger
// Self-checking testbench for the dedup cost ledger. A scoreboard keeps its
// own copy of the ledger table, the running total and the table limit. It
// predicts the response to every accepted request beat and checks each
// response beat against it in order. The run starts with directed requests,
// then steps through several table limits with random requests. It ends by
// filling the table, overflowing the total and reporting the table full.
// ----------------------------------------------------------------------------
module tb_dedup_cost_ledger;
    import dcl_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 250;
    localparam int POOL_MAX    = 96;

    class ledger_scoreboard;
        entry_t                rows[TABLE_DEPTH];
        int unsigned           entries;
        logic [COST_W-1:0]     total_debit;
        logic [LIMIT_W-1:0]    limit;
        rsp_t                  expected_receipts[$];
        int unsigned           failures;

        function new();
            entries     = 0;
            total_debit = '0;
            limit       = LIMIT_RESET;
            failures    = 0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] value);
            limit = value;
        endfunction

        function void predict_debit(req_t r);
            rsp_t              e;
            int unsigned       cap;
            logic [COST_W:0]   sum;
            bit                matched;
            e       = '0;
            matched = 1'b0;
            if (r.req_ident == '0 || r.req_gen == '0 || r.plan_seq == '0
                    || r.layer_index >= LAYER_LIMIT || r.expert_index >= EXPERT_LIMIT
                    || r.disposition == DISP_INVALID) begin
                e.status_code = STATUS_INVALID;
            end else if (r.disposition != DISP_NEW_MISS) begin
                e.status_code = (r.observed_cost != '0) ? STATUS_INVALID : STATUS_OK;
            end else if (r.observed_cost == '0) begin
                e.status_code = STATUS_INVALID;
            end else begin
                for (int i = 0; i < entries; i++) begin
                    if (!matched && rows[i].req_ident == r.req_ident
                            && rows[i].generation == r.req_gen
                            && rows[i].plan_seq == r.plan_seq
                            && rows[i].layer == r.layer_index
                            && rows[i].expert == r.expert_index[STORED_EXPERT_W-1:0]) begin
                        matched = 1'b1;
                        e.status_code = (rows[i].cost != r.observed_cost) ? STATUS_DRIFT
                                                                          : STATUS_OK;
                    end
                end
                if (!matched) begin
                    cap = (limit < TABLE_DEPTH) ? limit : TABLE_DEPTH;
                    sum = {1'b0, total_debit} + {1'b0, r.observed_cost};
                    if (entries >= cap) begin
                        e.status_code = STATUS_FULL;
                    end else if (sum[COST_W]) begin
                        e.status_code = STATUS_OVERFLOW;
                    end else begin
                        rows[entries].req_ident  = r.req_ident;
                        rows[entries].generation = r.req_gen;
                        rows[entries].plan_seq   = r.plan_seq;
                        rows[entries].layer      = r.layer_index;
                        rows[entries].expert     = r.expert_index[STORED_EXPERT_W-1:0];
                        rows[entries].cost       = r.observed_cost;
                        entries++;
                        total_debit    = sum[COST_W-1:0];
                        e.status_code  = STATUS_OK;
                        e.charged_cost = r.observed_cost;
                    end
                end
            end
            e.running_total = total_debit;
            e.entry_count   = ENTRY_CNT_W'(entries);
            expected_receipts.insert(expected_receipts.size(), e);
        endfunction

        function void check_receipt(rsp_t got);
            rsp_t e;
            if (expected_receipts.size() == 0) begin
                $error("unexpected response beat: status_code %0d", got.status_code);
                failures++;
                return;
            end
            e = expected_receipts.pop_front();
            if (got.status_code !== e.status_code) begin
                $error("status_code: expected %0d, actual %0d", e.status_code, got.status_code);
                failures++;
            end
            if (got.charged_cost !== e.charged_cost) begin
                $error("charged_cost: expected %0h, actual %0h", e.charged_cost,
                       got.charged_cost);
                failures++;
            end
            if (got.running_total !== e.running_total) begin
                $error("running_total: expected %0h, actual %0h", e.running_total,
                       got.running_total);
                failures++;
            end
            if (got.entry_count !== e.entry_count) begin
                $error("entry_count: expected %0d, actual %0d", e.entry_count, got.entry_count);
                failures++;
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [LIMIT_W-1:0] cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    req_t               s_data;
    logic               m_valid;
    logic               m_ready;
    rsp_t               m_data;

    logic               idle_on;
    logic               stall_request;
    int unsigned        hold_left;
    int unsigned        cycle_count;
    req_t               key_pool[$];
    ledger_scoreboard   ledger = new();

    dedup_cost_ledger #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The response side checks every beat and owns the long hold-off.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            ledger.check_receipt(m_data);
        end
        if (stall_request) begin
            stall_request <= 1'b0;
            hold_left     <= LONG_HOLD;
            m_ready       <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= !(idle_on && $urandom_range(99) < 31);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic req_t build_request(logic [KEY_W-1:0] rid, logic [KEY_W-1:0] gen,
                                           logic [KEY_W-1:0] seq, logic [LAYER_W-1:0] layer,
                                           logic [EXPERT_W-1:0] expert,
                                           logic [DISP_W-1:0] disp, logic [COST_W-1:0] cost);
        req_t r;
        r.req_ident     = rid;
        r.req_gen       = gen;
        r.plan_seq      = seq;
        r.layer_index   = layer;
        r.expert_index  = expert;
        r.disposition   = disp;
        r.observed_cost = cost;
        return r;
    endfunction

    function automatic req_t fresh_miss();
        req_t r;
        r = build_request(rand64(), rand64(), rand64(), LAYER_W'($urandom_range(0, 42)),
                          EXPERT_W'($urandom_range(0, 255)), DISP_NEW_MISS,
                          ($urandom_range(9) == 0) ? COST_W'($urandom)
                                                   : COST_W'($urandom_range(1, 1 << 20)));
        if (r.req_ident == '0) r.req_ident = 1;
        if (r.req_gen == '0) r.req_gen = 1;
        if (r.plan_seq == '0) r.plan_seq = 1;
        return r;
    endfunction

    function automatic req_t make_request();
        req_t        r;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30 || key_pool.size() == 0) begin
            r = fresh_miss();
            if (key_pool.size() >= POOL_MAX) key_pool.delete($urandom_range(POOL_MAX - 1));
            key_pool.insert(key_pool.size(), r);
        end else if (pick < 55) begin
            r = key_pool[$urandom_range(key_pool.size() - 1)];
            if ($urandom_range(99) < 40) begin
                r.observed_cost = r.observed_cost + COST_W'($urandom_range(1, 5));
            end
        end else if (pick < 65) begin
            r = key_pool[$urandom_range(key_pool.size() - 1)];
            case ($urandom_range(4))
                0: r.req_ident[$urandom_range(63)] ^= 1'b1;
                1: r.req_gen[$urandom_range(63)] ^= 1'b1;
                2: r.plan_seq[$urandom_range(63)] ^= 1'b1;
                3: r.layer_index = LAYER_W'($urandom_range(0, 42));
                default: r.expert_index = EXPERT_W'($urandom_range(0, 255));
            endcase
        end else if (pick < 78) begin
            r = fresh_miss();
            r.disposition   = $urandom_range(1) ? DISP_HIT : DISP_JOIN;
            r.observed_cost = ($urandom_range(3) == 0) ? rand64() : '0;
        end else if (pick < 89) begin
            r = fresh_miss();
            case ($urandom_range(5))
                0: r.req_ident = '0;
                1: r.req_gen = '0;
                2: r.plan_seq = '0;
                3: r.layer_index = LAYER_W'($urandom_range(43, 63));
                4: r.expert_index = EXPERT_W'($urandom_range(256, 511));
                default: r.disposition = DISP_INVALID;
            endcase
        end else begin
            r = build_request(rand64(), rand64(), rand64(), LAYER_W'($urandom),
                              EXPERT_W'($urandom), DISP_W'($urandom), rand64());
            // A random new miss keeps a small cost so the total does not overflow.
            if (r.disposition == DISP_NEW_MISS) r.observed_cost = COST_W'($urandom_range(0, 4096));
        end
        return r;
    endfunction

    task automatic send_request(input req_t r);
        if (idle_on) begin
            while ($urandom_range(99) < 31) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        ledger.predict_debit(r);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (ledger.expected_receipts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        ledger.set_limit(value);
        @(posedge aclk);
    endtask

    task automatic run_random_phase(input int unsigned items, input int unsigned stall_at);
        for (int unsigned n = 0; n < items; n++) begin
            if (n == stall_at) stall_request <= 1'b1;
            send_request(make_request());
        end
        drain_results();
    endtask

    initial begin
        req_t        key_a;
        req_t        key_b;
        req_t        r;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        idle_on       = 1'b1;
        stall_request = 1'b0;
        hold_left     = 0;
        cycle_count   = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        key_a = build_request('1, '1, '1, 6'd42, 9'd255, DISP_NEW_MISS, 64'd1000);
        key_b = build_request(64'd1, 64'd1, 64'd1, 6'd0, 9'd0, DISP_NEW_MISS, 64'd7);

        send_request(build_request('0, 64'd2, 64'd3, 6'd1, 9'd1, DISP_NEW_MISS, 64'd5));
        send_request(build_request(64'd1, '0, 64'd3, 6'd1, 9'd1, DISP_NEW_MISS, 64'd5));
        send_request(build_request(64'd1, 64'd2, '0, 6'd1, 9'd1, DISP_NEW_MISS, 64'd5));
        send_request(build_request(64'd1, 64'd2, 64'd3, 6'd43, 9'd1, DISP_NEW_MISS, 64'd5));
        send_request(build_request(64'd1, 64'd2, 64'd3, 6'd63, 9'd1, DISP_NEW_MISS, 64'd5));
        send_request(build_request(64'd1, 64'd2, 64'd3, 6'd1, 9'd256, DISP_NEW_MISS, 64'd5));
        send_request(build_request(64'd1, 64'd2, 64'd3, 6'd1, 9'd511, DISP_NEW_MISS, 64'd5));
        send_request(build_request(64'd1, 64'd2, 64'd3, 6'd1, 9'd1, DISP_INVALID, 64'd0));
        send_request(build_request(64'd1, 64'd2, 64'd3, 6'd1, 9'd1, DISP_HIT, 64'd0));
        send_request(build_request(64'd1, 64'd2, 64'd3, 6'd1, 9'd1, DISP_HIT, '1));
        send_request(build_request(64'd1, 64'd2, 64'd3, 6'd1, 9'd1, DISP_JOIN, 64'd0));
        send_request(build_request(64'd1, 64'd2, 64'd3, 6'd1, 9'd1, DISP_JOIN, 64'd1));
        send_request(build_request(64'd1, 64'd2, 64'd3, 6'd1, 9'd1, DISP_NEW_MISS, 64'd0));
        send_request(key_a);
        send_request(key_a);
        r = key_a;
        r.observed_cost = 64'd1001;
        send_request(r);
        send_request(key_b);
        r = key_b;
        r.layer_index   = 6'd1;
        r.observed_cost = 64'd9;
        send_request(r);
        r = key_a;
        r.disposition   = DISP_HIT;
        r.observed_cost = '0;
        send_request(r);
        send_request(key_b);
        key_pool.insert(key_pool.size(), key_a);
        key_pool.insert(key_pool.size(), key_b);
        drain_results();

        // The limit drops below the entry count; stored keys still match.
        write_limit(7'd1);
        run_random_phase(150, 150);
        write_limit(7'd0);
        run_random_phase(100, 100);

        write_limit(7'd20);
        idle_on <= 1'b0;
        run_random_phase(400, 400);
        idle_on <= 1'b1;

        write_limit(7'd45);
        run_random_phase(650, 150);
        write_limit(7'd10);
        run_random_phase(300, 300);

        write_limit(7'd64);
        while (ledger.entries < TABLE_DEPTH - 1) begin
            r = fresh_miss();
            r.observed_cost = COST_W'($urandom_range(1, 1000));
            send_request(r);
        end
        drain_results();

        // An out-of-range limit acts as the full table depth.
        write_limit(7'd127);
        r = fresh_miss();
        r.observed_cost = ~ledger.total_debit + 64'd1;
        send_request(r);
        r.observed_cost = ~ledger.total_debit;
        send_request(r);
        r = fresh_miss();
        r.observed_cost = 64'd1;
        send_request(r);
        run_random_phase(80, 80);

        repeat (20) @(posedge aclk);
        if (ledger.failures == 0 && ledger.expected_receipts.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
